>>> rtl/core/assert_macros.svh
// assertion macros for the checker file nfcs_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/nfcs_pkg.sv
// types, codes and command-sequence table of the nor flash command sequencer
// no dependencies
package nfcs_pkg;

  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 20;
  localparam int DATA_W  = 8;
  localparam int KIND_W  = 2;
  localparam int BUS_W   = 23;
  localparam int STAT_W  = 3;
  localparam int SPC_W   = 4;
  localparam int LIMIT_W = 14;
  localparam int CFG_W   = 14;
  localparam int STEP_W  = 3;
  localparam int JOB_DEPTH = 4;

  localparam logic [CMD_W-1:0] CMD_IDENTIFY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHIP_ERASE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BYPASS_ENTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROGRAM      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BYPASS_EXIT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ         = 3'd5;
  localparam logic [CMD_W-1:0] CMD_VERIFY       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_REPLY        = 3'd7;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TIMEOUT    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ERASE_FAIL = 3'd3;
  localparam logic [STAT_W-1:0] STAT_PROG_FAIL  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_MISMATCH   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_BUSY       = 3'd6;

  localparam logic CFG_SPACING    = 1'b0;
  localparam logic CFG_POLL_LIMIT = 1'b1;

  localparam logic [SPC_W-1:0]   SPACING_RESET = 4'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 14'd9999;

  localparam logic [11:0] OFF_UNLOCK1 = 12'haaa;
  localparam logic [11:0] OFF_UNLOCK2 = 12'h555;
  localparam logic [11:0] OFF_ID_DEV  = 12'h002;
  localparam logic [BUS_W-1:0] BUS_STATUS = 23'd16;

  localparam logic [DATA_W-1:0] BYTE_ZERO        = 8'h00;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK1     = 8'haa;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK2     = 8'h55;
  localparam logic [DATA_W-1:0] BYTE_AUTOSELECT  = 8'h90;
  localparam logic [DATA_W-1:0] BYTE_ERASE_SETUP = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_CHIP_ERASE  = 8'h10;
  localparam logic [DATA_W-1:0] BYTE_BYPASS      = 8'h20;
  localparam logic [DATA_W-1:0] BYTE_PROGRAM     = 8'ha0;
  localparam logic [DATA_W-1:0] BYTE_RESET       = 8'hf0;
  localparam logic [DATA_W-1:0] BYTE_MAN_A       = 8'h01;
  localparam logic [DATA_W-1:0] BYTE_MAN_B       = 8'h20;
  localparam logic [DATA_W-1:0] BYTE_DEVICE      = 8'h5b;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BUS_W-1:0]  bus_address;
    logic [DATA_W-1:0] bus_data;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    SEQ_IDENT,
    SEQ_ERASE,
    SEQ_BYPASS_ENTER,
    SEQ_PROGRAM,
    SEQ_BYPASS_EXIT,
    SEQ_READ_HERE,
    SEQ_DONE_ZERO,
    SEQ_READ_ZERO,
    SEQ_ID_END,
    SEQ_ERASE_END,
    SEQ_POLL_STATUS,
    SEQ_DONE_HERE
  } seq_t;

  typedef struct packed {
    seq_t              seq;
    logic [ADDR_W-1:0] offset;
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
  } job_t;

  typedef enum logic [2:0] {
    ASEL_UNLOCK1,
    ASEL_UNLOCK2,
    ASEL_ID_DEV,
    ASEL_ZERO,
    ASEL_STATUS,
    ASEL_HERE
  } addr_sel_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    addr_sel_t         addr_sel;
    logic              job_data;
    logic [DATA_W-1:0] byte_val;
    logic              last;
  } step_t;

  function automatic step_t mk(logic [KIND_W-1:0] kind, addr_sel_t asel, logic jd,
                               logic [DATA_W-1:0] bv, logic lst);
    step_t s;
    s.kind     = kind;
    s.addr_sel = asel;
    s.job_data = jd;
    s.byte_val = bv;
    s.last     = lst;
    return s;
  endfunction

  function automatic step_t step_lookup(seq_t seq, logic [STEP_W-1:0] step);
    step_t s;
    s = mk(KIND_DONE, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b1);
    unique case (seq)
      SEQ_IDENT: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_UNLOCK1, 1'b0);
          3'd1:    s = mk(KIND_WRITE, ASEL_UNLOCK2, 1'b0, BYTE_UNLOCK2, 1'b0);
          3'd2:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_AUTOSELECT, 1'b0);
          default: s = mk(KIND_READ, ASEL_ID_DEV, 1'b0, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_ERASE: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_UNLOCK1, 1'b0);
          3'd1:    s = mk(KIND_WRITE, ASEL_UNLOCK2, 1'b0, BYTE_UNLOCK2, 1'b0);
          3'd2:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_ERASE_SETUP, 1'b0);
          3'd3:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_UNLOCK1, 1'b0);
          3'd4:    s = mk(KIND_WRITE, ASEL_UNLOCK2, 1'b0, BYTE_UNLOCK2, 1'b0);
          3'd5:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_CHIP_ERASE, 1'b0);
          default: s = mk(KIND_READ, ASEL_STATUS, 1'b0, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_BYPASS_ENTER: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_UNLOCK1, 1'b0);
          3'd1:    s = mk(KIND_WRITE, ASEL_UNLOCK2, 1'b0, BYTE_UNLOCK2, 1'b0);
          3'd2:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_BYPASS, 1'b0);
          default: s = mk(KIND_DONE, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_PROGRAM: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_ZERO, 1'b0, BYTE_PROGRAM, 1'b0);
          3'd1:    s = mk(KIND_WRITE, ASEL_HERE, 1'b1, BYTE_ZERO, 1'b0);
          default: s = mk(KIND_READ, ASEL_HERE, 1'b0, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_BYPASS_EXIT: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_ZERO, 1'b0, BYTE_AUTOSELECT, 1'b0);
          3'd1:    s = mk(KIND_WRITE, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b0);
          3'd2:    s = mk(KIND_WRITE, ASEL_ZERO, 1'b0, BYTE_RESET, 1'b0);
          default: s = mk(KIND_DONE, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_READ_HERE:   s = mk(KIND_READ, ASEL_HERE, 1'b0, BYTE_ZERO, 1'b1);
      SEQ_DONE_ZERO:   s = mk(KIND_DONE, ASEL_ZERO, 1'b1, BYTE_ZERO, 1'b1);
      SEQ_READ_ZERO:   s = mk(KIND_READ, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b1);
      SEQ_ID_END: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_ZERO, 1'b0, BYTE_RESET, 1'b0);
          default: s = mk(KIND_DONE, ASEL_ZERO, 1'b1, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_ERASE_END: begin
        unique case (step)
          3'd0:    s = mk(KIND_WRITE, ASEL_UNLOCK1, 1'b0, BYTE_RESET, 1'b0);
          default: s = mk(KIND_DONE, ASEL_ZERO, 1'b1, BYTE_ZERO, 1'b1);
        endcase
      end
      SEQ_POLL_STATUS: s = mk(KIND_READ, ASEL_STATUS, 1'b0, BYTE_ZERO, 1'b1);
      SEQ_DONE_HERE:   s = mk(KIND_DONE, ASEL_HERE, 1'b1, BYTE_ZERO, 1'b1);
      default:         s = mk(KIND_DONE, ASEL_ZERO, 1'b0, BYTE_ZERO, 1'b1);
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/nfcs_queue.sv
// job queue between the command front end and the bus sequence back end
// depends on nfcs_pkg
module nfcs_queue import nfcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic avail
);

  localparam int PTR_W = $clog2(JOB_DEPTH);
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             slots [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(JOB_DEPTH);
  assign avail  = count != '0;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/nfcs_front.sv
// front end: takes requests, tracks the command phase and queues bus jobs
// depends on nfcs_pkg
module nfcs_front import nfcs_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  in_item_t           item,
  input  logic [LIMIT_W-1:0] poll_limit,
  output logic               job_valid,
  output job_t               job
);

  localparam int OW = (OFFSET_BITS < ADDR_W) ? OFFSET_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OW) - 64'd1);

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_ID_TYPE = 8'b0000_0010,
    PH_ID_MAN  = 8'b0000_0100,
    PH_ERASE   = 8'b0000_1000,
    PH_PROG    = 8'b0001_0000,
    PH_RECHECK = 8'b0010_0000,
    PH_READ    = 8'b0100_0000,
    PH_VERIFY  = 8'b1000_0000
  } phase_t;

  phase_t             phase, phase_next;
  logic [LIMIT_W-1:0] poll_remaining, poll_remaining_next;
  logic [DATA_W-1:0]  expected_byte, expected_byte_next;
  logic [ADDR_W-1:0]  pending_offset, pending_offset_next;
  logic [DATA_W-1:0]  device_type_byte, device_type_byte_next;
  logic               identified, identified_next;

  logic [ADDR_W-1:0]  addr_m;
  logic               bit7_match;
  logic               man_ok;

  assign addr_m     = item.address & OFF_MASK;
  assign bit7_match = item.data[7] == expected_byte[7];
  assign man_ok     = (item.data == BYTE_MAN_A || item.data == BYTE_MAN_B) &&
                      device_type_byte == BYTE_DEVICE;

  always_comb begin
    phase_next            = phase;
    poll_remaining_next   = poll_remaining;
    expected_byte_next    = expected_byte;
    pending_offset_next   = pending_offset;
    device_type_byte_next = device_type_byte;
    identified_next       = identified;
    job_valid             = 1'b0;
    job.seq               = SEQ_DONE_ZERO;
    job.offset            = pending_offset;
    job.data              = item.data;
    job.status            = STAT_OK;
    if (accept) begin
      if (item.command == CMD_REPLY) begin
        job_valid = phase != PH_IDLE;
        unique case (phase)
          PH_ID_TYPE: begin
            device_type_byte_next = item.data;
            job.seq               = SEQ_READ_ZERO;
            phase_next            = PH_ID_MAN;
          end
          PH_ID_MAN: begin
            job.seq    = SEQ_ID_END;
            job.status = man_ok ? STAT_OK : STAT_UNKNOWN;
            if (man_ok) begin
              identified_next = 1'b1;
            end
            phase_next = PH_IDLE;
          end
          PH_ERASE: begin
            if (item.data[7] || item.data[5]) begin
              job.seq    = SEQ_ERASE_END;
              job.status = item.data[7] ? STAT_OK : STAT_ERASE_FAIL;
              phase_next = PH_IDLE;
            end else if (poll_remaining <= LIMIT_W'(1)) begin
              poll_remaining_next = '0;
              job.seq             = SEQ_ERASE_END;
              job.status          = STAT_TIMEOUT;
              phase_next          = PH_IDLE;
            end else begin
              poll_remaining_next = poll_remaining - LIMIT_W'(1);
              job.seq             = SEQ_POLL_STATUS;
            end
          end
          PH_PROG: begin
            if (bit7_match) begin
              job.seq    = SEQ_DONE_HERE;
              phase_next = PH_IDLE;
            end else begin
              job.seq = SEQ_READ_HERE;
              if (item.data[5]) begin
                phase_next = PH_RECHECK;
              end
            end
          end
          PH_RECHECK: begin
            if (!bit7_match) begin
              job.seq    = SEQ_DONE_HERE;
              job.status = STAT_PROG_FAIL;
              phase_next = PH_IDLE;
            end else begin
              job.seq    = SEQ_READ_HERE;
              phase_next = PH_PROG;
            end
          end
          PH_READ: begin
            job.seq    = SEQ_DONE_HERE;
            phase_next = PH_IDLE;
          end
          PH_VERIFY: begin
            job.seq    = SEQ_DONE_HERE;
            job.status = (item.data == expected_byte) ? STAT_OK : STAT_MISMATCH;
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end else if (phase != PH_IDLE) begin
        job_valid  = 1'b1;
        job.seq    = SEQ_DONE_ZERO;
        job.data   = BYTE_ZERO;
        job.status = STAT_BUSY;
      end else begin
        job_valid = 1'b1;
        unique case (item.command)
          CMD_IDENTIFY: begin
            if (identified) begin
              job.seq  = SEQ_DONE_ZERO;
              job.data = device_type_byte;
            end else begin
              job.seq    = SEQ_IDENT;
              phase_next = PH_ID_TYPE;
            end
          end
          CMD_CHIP_ERASE: begin
            job.seq             = SEQ_ERASE;
            poll_remaining_next = (poll_limit == '0) ? LIMIT_W'(1) : poll_limit;
            phase_next          = PH_ERASE;
          end
          CMD_BYPASS_ENTER: begin
            job.seq  = SEQ_BYPASS_ENTER;
            job.data = BYTE_ZERO;
          end
          CMD_PROGRAM: begin
            job.seq             = SEQ_PROGRAM;
            job.offset          = addr_m;
            pending_offset_next = addr_m;
            expected_byte_next  = item.data;
            phase_next          = PH_PROG;
          end
          CMD_BYPASS_EXIT: begin
            job.seq  = SEQ_BYPASS_EXIT;
            job.data = BYTE_ZERO;
          end
          CMD_READ: begin
            job.seq             = SEQ_READ_HERE;
            job.offset          = addr_m;
            pending_offset_next = addr_m;
            phase_next          = PH_READ;
          end
          default: begin
            job.seq             = SEQ_READ_HERE;
            job.offset          = addr_m;
            pending_offset_next = addr_m;
            expected_byte_next  = item.data;
            phase_next          = PH_VERIFY;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      poll_remaining   <= '0;
      expected_byte    <= '0;
      pending_offset   <= '0;
      device_type_byte <= '0;
      identified       <= 1'b0;
    end else begin
      phase            <= phase_next;
      poll_remaining   <= poll_remaining_next;
      expected_byte    <= expected_byte_next;
      pending_offset   <= pending_offset_next;
      device_type_byte <= device_type_byte_next;
      identified       <= identified_next;
    end
  end

endmodule

>>> rtl/core/nfcs_back.sv
// back end: expands queued jobs into bus writes, reads and done results
// depends on nfcs_pkg
module nfcs_back import nfcs_pkg::*; #(
  parameter int EFF_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [EFF_W-1:0] eff_spacing,
  input  logic             job_avail,
  input  job_t             job,
  output logic             job_pop,
  output logic             empty,
  input  logic             pop,
  output result_t          result
);

  localparam int PROD_W = ADDR_W + EFF_W;

  logic [STEP_W-1:0] step;
  logic              out_valid;
  step_t             info;
  logic [ADDR_W-1:0] off;
  logic [PROD_W-1:0] prod;
  logic [BUS_W-1:0]  scaled;
  result_t           res;
  logic              advance;

  assign info = step_lookup(job.seq, step);

  always_comb begin
    unique case (info.addr_sel)
      ASEL_UNLOCK1: off = ADDR_W'(OFF_UNLOCK1);
      ASEL_UNLOCK2: off = ADDR_W'(OFF_UNLOCK2);
      ASEL_ID_DEV:  off = ADDR_W'(OFF_ID_DEV);
      ASEL_HERE:    off = job.offset;
      default:      off = '0;
    endcase
  end

  assign prod   = PROD_W'(off) * PROD_W'(eff_spacing);
  assign scaled = BUS_W'({{BUS_W{1'b0}}, prod});

  always_comb begin
    res.kind        = info.kind;
    res.bus_address = (info.addr_sel == ASEL_STATUS) ? BUS_STATUS : scaled;
    res.bus_data    = info.job_data ? job.data : info.byte_val;
    res.status      = (info.kind == KIND_DONE) ? job.status : STAT_OK;
    res.last        = info.last;
  end

  assign advance = job_avail && (!out_valid || pop);
  assign job_pop = advance && info.last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      step      <= info.last ? '0 : step + STEP_W'(1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

>>> rtl/core/nor_flash_command_sequencer.sv
// Host-side command sequencer for a parallel NOR flash. A request is taken on
// every cycle in which push is high and full is low; full rises only when the
// four-entry job queue between the front end and the bus back end is full.
// Each request becomes 0 to 7 results (bus writes, bus read requests and at
// most one done), which the back end hands out one per cycle while pop keeps
// up with them; the first result of a request passes through the job queue
// and the back end's result register before it reaches the result ports.
// Results per request: identify 4 (1 once identified), chip erase 7,
// bypass enter and exit 4, program 3, read, verify and a busy rejection 1,
// replies 0-2. No clearing pass follows reset.
// Bus addresses, save the fixed status address, are flash offsets times the
// clamped spacing; the flash base is added outside.
// depends on nfcs_pkg, nfcs_front, nfcs_queue, nfcs_back
module nor_flash_command_sequencer import nfcs_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int MAX_SPACING = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         item,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int EFF_W = $clog2(MAX_SPACING + 1);

  logic [SPC_W-1:0]   spacing;
  logic [LIMIT_W-1:0] erase_poll_limit;
  logic [SPC_W:0]     spc_ext;
  logic [EFF_W-1:0]   eff_spacing;
  logic               accept;
  logic               job_valid;
  job_t               job_in;
  job_t               job_out;
  logic               job_avail;
  logic               job_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign spc_ext   = {1'b0, spacing};

  always_comb begin
    if (spc_ext == '0) begin
      eff_spacing = EFF_W'(1);
    end else if (spc_ext > (SPC_W + 1)'(MAX_SPACING)) begin
      eff_spacing = EFF_W'(MAX_SPACING);
    end else begin
      eff_spacing = EFF_W'(spc_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing          <= SPACING_RESET;
      erase_poll_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPACING:    spacing <= cfg_data[SPC_W-1:0];
        CFG_POLL_LIMIT: erase_poll_limit <= cfg_data[LIMIT_W-1:0];
        default:        spacing <= spacing;
      endcase
    end
  end

  nfcs_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .poll_limit(erase_poll_limit),
    .job_valid (job_valid),
    .job       (job_in)
  );

  nfcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (job_valid),
    .wr_job(job_in),
    .full  (full),
    .rd_en (job_pop),
    .rd_job(job_out),
    .avail (job_avail)
  );

  nfcs_back #(
    .EFF_W(EFF_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_spacing(eff_spacing),
    .job_avail  (job_avail),
    .job        (job_out),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> rtl/core/nfcs_checker.sv
// port-level checks of the nor flash command sequencer, bound to the top level
// depends on nfcs_pkg and assert_macros.svh
`include "assert_macros.svh"

module nfcs_checker import nfcs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  `CHK_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "not clear after reset")
  `CHK_ASSERT(a_result_holds, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while waiting")
  `CHK_ASSERT(a_done_is_last, clk, rst, (!empty && result.kind == KIND_DONE) |-> result.last, "done result not marked last")
  `CHK_ASSERT(a_bus_status_ok, clk, rst, (!empty && result.kind != KIND_DONE) |-> (result.status == STAT_OK), "bus operation with status")

endmodule

bind nor_flash_command_sequencer nfcs_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
